>>> rtl/fixed_block_pool_allocator_macros.svh
// ----------------------------------------------------------------------------
// Block pool allocator assertion macros
// Shared assertion shorthands for the allocator RTL, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only while the block is out of reset.
`define FBPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define FBPA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FBPA_ASSERT(lbl, prop, msg)
`define FBPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// Block pool allocator package
// Field widths, request and status codes, and the structs shared by the RTL.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int ADDR_W  = 32;
    localparam int BYTES_W = 16;
    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int USED_W  = 11;
    // Common width for comparing indices against the block count.
    localparam int CMP_W   = 17;

    localparam logic [USED_W-1:0] USED_MAX = 11'h7FF;

    // Configuration register indices.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd2;

    localparam logic [ADDR_W-1:0]  RST_POOL_BASE     = 32'd0;
    localparam logic [BYTES_W-1:0] RST_BLOCK_BYTES   = 16'd8;
    localparam logic [COUNT_W-1:0] RST_BLOCKS_IN_USE = 11'd1024;

    typedef enum logic [1:0] {
        REQ_ACQUIRE = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_NONE    = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_EMPTY     = 2'd1,
        STS_TOO_BIG   = 2'd2,
        STS_BAD_INDEX = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_FIN  = 2'd2
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [BYTES_W-1:0] bytes;
        logic [COUNT_W-1:0] blocks;
    } t_cfg;

    typedef struct packed {
        t_req_kind          kind;
        logic [BYTES_W-1:0] want;
        logic [INDEX_W-1:0] back;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [INDEX_W-1:0] index;
        logic [USED_W-1:0]  used;
        logic               found;
    } t_res;

endpackage

>>> rtl/fbpa_link_ram.sv
// ----------------------------------------------------------------------------
// Free list link memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fbpa_link_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// Free list controller
// Holds the list head, fresh watermark and used count, and runs each request
// through a read-modify-write of the link memory.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_macros.svh"

module fbpa_ctrl import fbpa_pkg::*; #(
    parameter int MAX_BLOCKS = 1024,
    parameter int PROD_W     = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_req              i_req,
    input  t_cfg              i_cfg,
    input  logic              i_out_free,
    output logic              o_ready,
    output logic              o_done,
    output t_res              o_res,
    output logic [PROD_W-1:0] o_prod
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int LNK_W = IDX_W + 1;
    localparam logic [LNK_W-1:0] LNK_NONE  = LNK_W'(MAX_BLOCKS);
    localparam logic [CMP_W-1:0] TOTAL_MAX = CMP_W'(MAX_BLOCKS);

    t_state             r_state, n_state;
    t_req               r_req;
    logic [LNK_W-1:0]   r_head, n_head;
    logic [LNK_W-1:0]   r_fresh, n_fresh;
    logic [USED_W-1:0]  r_used, n_used;
    t_status            r_status, w_status;
    logic [IDX_W-1:0]   r_blk, w_blk;
    logic               r_found, w_found;
    logic [PROD_W-1:0]  r_prod;

    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [IDX_W-1:0]   w_raddr;
    logic [LNK_W-1:0]   w_link;
    logic               w_head_valid;
    logic [CMP_W-1:0]   w_total;

    // The link of the current head is read every cycle; it is valid in EXEC
    // because the head and the memory only change at the end of EXEC.
    assign w_head_valid = (r_head != LNK_NONE);
    assign w_raddr      = w_head_valid ? r_head[IDX_W-1:0] : '0;
    assign w_waddr      = IDX_W'(r_req.back);

    fbpa_link_ram #(
        .DEPTH (MAX_BLOCKS),
        .AW    (IDX_W),
        .DW    (LNK_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_head),
        .i_raddr (w_raddr),
        .o_rdata (w_link)
    );

    assign w_total = (CMP_W'(i_cfg.blocks) > TOTAL_MAX) ? TOTAL_MAX : CMP_W'(i_cfg.blocks);

    always_comb begin
        n_head   = r_head;
        n_fresh  = r_fresh;
        n_used   = r_used;
        w_status = STS_OK;
        w_blk    = '0;
        w_found  = 1'b0;
        w_we     = 1'b0;
        if (r_state == ST_EXEC) begin
            unique case (r_req.kind)
                REQ_ACQUIRE: begin
                    if (r_req.want > i_cfg.bytes) begin
                        w_status = STS_TOO_BIG;
                    end else if (w_head_valid) begin
                        w_blk   = r_head[IDX_W-1:0];
                        n_head  = w_link;
                        w_found = 1'b1;
                    end else if (CMP_W'(r_fresh) < w_total) begin
                        w_blk   = r_fresh[IDX_W-1:0];
                        n_fresh = r_fresh + 1'b1;
                        w_found = 1'b1;
                    end else begin
                        w_status = STS_EMPTY;
                    end
                    if (w_found && (r_used != USED_MAX)) begin
                        n_used = r_used + 1'b1;
                    end
                end
                REQ_RELEASE: begin
                    if (CMP_W'(r_req.back) >= w_total) begin
                        w_status = STS_BAD_INDEX;
                    end else begin
                        w_we   = 1'b1;
                        n_head = LNK_W'(r_req.back);
                        if (r_used != '0) begin
                            n_used = r_used - 1'b1;
                        end
                    end
                end
                REQ_CLEAR: begin
                    n_head  = LNK_NONE;
                    n_fresh = '0;
                    n_used  = '0;
                end
                REQ_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_out_free) begin
                    n_state = i_accept ? ST_EXEC : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_ready = 1'b0;
        o_done  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
            end
            ST_EXEC: begin
            end
            ST_FIN: begin
                o_ready = i_out_free;
                o_done  = i_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= LNK_NONE;
            r_fresh <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fresh <= n_fresh;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_req <= i_req;
        end
        if (r_state == ST_EXEC) begin
            r_status <= w_status;
            r_blk    <= w_blk;
            r_found  <= w_found;
            r_prod   <= PROD_W'(w_blk) * PROD_W'(i_cfg.bytes);
        end
    end

    assign o_res.status = r_status;
    assign o_res.index  = INDEX_W'(r_blk);
    assign o_res.used   = r_used;
    assign o_res.found  = r_found;
    assign o_prod       = r_prod;

    `FBPA_ASSERT(a_exec_then_fin, (r_state == ST_EXEC) |=> (r_state == ST_FIN), "EXEC not followed by FIN")
    `FBPA_ASSERT(a_write_on_release, w_we |-> (r_state == ST_EXEC && r_req.kind == REQ_RELEASE), "link write outside a release")
    `FBPA_ASSERT(a_grant_counts, (w_found && r_used != USED_MAX) |=> (r_used == $past(r_used) + 1'b1), "grant did not raise the used count")

endmodule

>>> rtl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Hands out and takes back equal-sized blocks from a last-in, first-out list.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: s_tuser carries the request type (acquire,
// release, pool reset), s_tdata the requested size and the returned index.
// Each request gives exactly one result on the m_ stream: status, granted
// index, granted byte address and the used count after the request.
// Released blocks are linked in an on-chip memory; blocks never handed out
// since the last pool reset are taken from a watermark in ascending order.
// Each request runs through an execute state, which uses the head's link and
// writes back the list, then a finish state that loads the output register; a
// new request is taken only while idle or in the finish state.
// Reset (i_rst_n low, synchronous) restores the register defaults and leaves
// the whole pool free at once; there is no clearing pass.
// When m_tready is low the finished result waits in the output register;
// one more request may still be accepted and worked on, but its result and
// any later request wait until the held result is taken.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_wdata while the
// block is idle.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_macros.svh"

module fixed_block_pool_allocator import fbpa_pkg::*; #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_wdata,
    // Request stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // want_bytes[15:0], give_back[25:16]
    input  logic [1:0]           s_tuser,   // req_type[1:0]
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata    // status[1:0], granted_index[11:2],
                                            // granted_address[43:12],
                                            // used_count[54:44]
);

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int PROD_W = IDX_W + BYTES_W;
    localparam int OUT_W  = 56;
    localparam int ST_LO  = 0;
    localparam int IX_LO  = ST_LO + 2;
    localparam int AD_LO  = IX_LO + INDEX_W;

    t_cfg              r_cfg;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data, n_out_data;

    t_req              w_req;
    t_res              w_res;
    logic [PROD_W-1:0] w_prod;
    logic [ADDR_W-1:0] w_addr;
    logic              w_accept;
    logic              w_done;
    logic              w_out_free;
    logic              w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base   <= RST_POOL_BASE;
            r_cfg.bytes  <= RST_BLOCK_BYTES;
            r_cfg.blocks <= RST_BLOCKS_IN_USE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POOL_BASE:     r_cfg.base   <= i_cfg_wdata;
                CFG_BLOCK_BYTES:   r_cfg.bytes  <= i_cfg_wdata[BYTES_W-1:0];
                CFG_BLOCKS_IN_USE: r_cfg.blocks <= i_cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_req.kind = t_req_kind'(s_tuser[1:0]);
    assign w_req.want = s_tdata[15:0];
    assign w_req.back = s_tdata[25:16];

    assign w_out_free = !r_out_valid || m_tready;
    assign w_accept   = s_tvalid && w_ready;

    fbpa_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .PROD_W     (PROD_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_req      (w_req),
        .i_cfg      (r_cfg),
        .i_out_free (w_out_free),
        .o_ready    (w_ready),
        .o_done     (w_done),
        .o_res      (w_res),
        .o_prod     (w_prod)
    );

    // The address wraps modulo 2^32 by the width of the sum.
    assign w_addr     = w_res.found ? (r_cfg.base + ADDR_W'(w_prod)) : '0;
    assign n_out_data = OUT_W'({w_res.used, w_addr, w_res.index, w_res.status});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_data <= n_out_data;
        end
    end

    assign s_tready = w_ready;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    `FBPA_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "request accepted while one is in flight")
    `FBPA_ASSERT(a_fail_no_grant, (m_tvalid && m_tdata[IX_LO-1:ST_LO] != STS_OK) |-> (m_tdata[AD_LO+ADDR_W-1:IX_LO] == '0), "failed request carries a grant")
    `FBPA_ASSERT(a_grant_used, (w_done && w_res.found) |-> (w_res.used != '0), "grant with zero used count")

endmodule

>>> tb/fbpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool allocator checker
// Watches the configuration port and both streams, keeps its own copy of the
// free list, predicts one reply per request and compares every reply taken
// from the result stream against the oldest prediction.
// ----------------------------------------------------------------------------
module fbpa_checker import fbpa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_wdata,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [31:0]          i_s_tdata,   // want_bytes[15:0], give_back[25:16]
    input  logic [1:0]           i_s_tuser,   // req_type[1:0]
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [55:0]          i_m_tdata,   // status[1:0], granted_index[11:2],
                                              // granted_address[43:12],
                                              // used_count[54:44]
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    localparam int POOL_MAX = 1024;
    localparam logic [COUNT_W-1:0] NO_LINK = 11'd1024;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        t_status            status;
        logic [INDEX_W-1:0] index;
        logic [ADDR_W-1:0]  addr;
        logic [USED_W-1:0]  used;
    } t_reply;

    logic [ADDR_W-1:0]  base_q;
    logic [BYTES_W-1:0] bytes_q;
    logic [COUNT_W-1:0] blocks_q;

    logic [COUNT_W-1:0] link_mem [POOL_MAX];
    logic [COUNT_W-1:0] head_q;
    logic [COUNT_W-1:0] fresh_q;
    logic [USED_W-1:0]  used_q;

    t_reply replies_due [$];
    int     fails   = 0;
    int     checked = 0;

    function automatic t_reply serve_request(t_req_kind kind, logic [BYTES_W-1:0] want,
                                             logic [INDEX_W-1:0] back);
        t_reply             r;
        logic [COUNT_W-1:0] total;
        logic [COUNT_W-1:0] blk;
        logic               found;
        r.status = STS_OK;
        r.index  = '0;
        r.addr   = '0;
        found    = 1'b0;
        blk      = '0;
        // Counts above the pool size behave as the full pool.
        total = (blocks_q > NO_LINK) ? NO_LINK : blocks_q;
        case (kind)
            REQ_ACQUIRE: begin
                if (want > bytes_q) begin
                    r.status = STS_TOO_BIG;
                end else begin
                    // Released blocks go out first, then never-used ones.
                    if (head_q < NO_LINK) begin
                        blk    = head_q;
                        head_q = link_mem[blk[INDEX_W-1:0]];
                        found  = 1'b1;
                    end else if (fresh_q < total) begin
                        blk     = fresh_q;
                        fresh_q = fresh_q + 1'b1;
                        found   = 1'b1;
                    end
                    if (found) begin
                        r.index = blk[INDEX_W-1:0];
                        r.addr  = base_q + {21'd0, blk} * {16'd0, bytes_q};
                        if (used_q != USED_MAX) used_q = used_q + 1'b1;
                    end else begin
                        r.status = STS_EMPTY;
                    end
                end
            end
            REQ_RELEASE: begin
                if ({1'b0, back} >= total) begin
                    r.status = STS_BAD_INDEX;
                end else begin
                    link_mem[back] = head_q;
                    head_q         = {1'b0, back};
                    if (used_q != '0) used_q = used_q - 1'b1;
                end
            end
            REQ_CLEAR: begin
                head_q  = NO_LINK;
                fresh_q = '0;
                used_q  = '0;
            end
            default: ;
        endcase
        r.used = used_q;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply got;
        t_reply exp_r;
        if (!i_rst_n) begin
            base_q   = RST_POOL_BASE;
            bytes_q  = RST_BLOCK_BYTES;
            blocks_q = RST_BLOCKS_IN_USE;
            head_q   = NO_LINK;
            fresh_q  = '0;
            used_q   = '0;
            replies_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POOL_BASE:     base_q   = i_cfg_wdata;
                    CFG_BLOCK_BYTES:   bytes_q  = i_cfg_wdata[BYTES_W-1:0];
                    CFG_BLOCKS_IN_USE: blocks_q = i_cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status = t_status'(i_m_tdata[1:0]);
                got.index  = i_m_tdata[11:2];
                got.addr   = i_m_tdata[43:12];
                got.used   = i_m_tdata[54:44];
                if (replies_due.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("[%0t] unexpected reply: status %0d index %0d addr %h used %0d",
                                 $realtime, got.status, got.index, got.addr, got.used);
                end else begin
                    exp_r = replies_due.pop_front();
                    checked++;
                    if (got.status !== exp_r.status || got.index !== exp_r.index ||
                        got.addr !== exp_r.addr || got.used !== exp_r.used) begin
                        fails++;
                        if (fails <= REPORT_MAX)
                            $display({"[%0t] reply %0d mismatch: expected status %0d index %0d",
                                      " addr %h used %0d, got status %0d index %0d addr %h",
                                      " used %0d"},
                                     $realtime, checked, exp_r.status, exp_r.index,
                                     exp_r.addr, exp_r.used, got.status, got.index,
                                     got.addr, got.used);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                replies_due.push_back(serve_request(t_req_kind'(i_s_tuser),
                                                    i_s_tdata[15:0], i_s_tdata[25:16]));
        end
        // Registered so that the stimulus side reads them without a race.
        o_pending    <= replies_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool allocator testbench
// Drives request bursts with random gaps through several register settings,
// stalls the result stream on its own pattern, and reports the verdict from
// the checker's failure count and its count of outstanding replies.
// ----------------------------------------------------------------------------
module tb_top;
    import fbpa_pkg::*;

    localparam int LIMIT = 500000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [ADDR_W-1:0]    i_cfg_wdata = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata     = '0;   // want_bytes[15:0], give_back[25:16]
    logic [1:0]           s_tuser     = '0;   // req_type[1:0]
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [55:0]          m_tdata;            // status[1:0], granted_index[11:2],
                                              // granted_address[43:12],
                                              // used_count[54:44]

    int fail_count;
    int pending;
    int checked;

    int cycles      = 0;
    int items_sent  = 0;
    int settings    = 1;
    int burst_left  = 0;
    bit steady      = 1'b0;
    int cur_bytes   = 8;
    int cur_blocks  = 1024;
    int rx_mode     = 0;
    int rx_left     = 0;
    int rx_tick     = 0;

    fixed_block_pool_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    fbpa_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Run stopped after %0d cycles with %0d replies outstanding.",
                     cycles, pending);
            $display("** fixed_block_pool_allocator: FAILED **");
            $finish;
        end
    end

    // The result side switches between always ready, coin flips, long
    // stalls and a fixed duty pattern.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(10, 60);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((rx_tick % 5) < 3);
        endcase
    end

    task automatic pace_sender();
        if (steady || burst_left > 0) begin
            if (!steady) burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic send_req(input t_req_kind kind, input logic [BYTES_W-1:0] want,
                            input logic [INDEX_W-1:0] back);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, back, want};
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
        pace_sender();
    endtask

    // Returns once every reply of the requests sent so far has been taken.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [31:0] base, input logic [31:0] bytes,
                                input logic [31:0] blocks, input bit poke_unused);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_POOL_BASE;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_BLOCK_BYTES;
        i_cfg_wdata <= bytes;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_BLOCKS_IN_USE;
        i_cfg_wdata <= blocks;
        @(posedge i_clk);
        if (poke_unused) begin
            i_cfg_idx   <= CFG_UNUSED;
            i_cfg_wdata <= $urandom;
            @(posedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        cur_bytes  = int'(bytes[15:0]);
        cur_blocks = int'(blocks[10:0]);
        settings++;
    endtask

    task automatic run_random(input int n);
        int                 pick;
        int                 lim;
        logic [BYTES_W-1:0] w;
        logic [INDEX_W-1:0] b;
        lim = (cur_blocks > 1024) ? 1024 : cur_blocks;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 9) == 0) w = 16'($urandom);
                else                           w = 16'($urandom_range(0, cur_bytes));
                send_req(REQ_ACQUIRE, w, 10'($urandom));
            end else if (pick < 87) begin
                // Mostly indices inside the pool, the low ones being the likely owners.
                if (lim == 0 || $urandom_range(0, 9) == 0) b = 10'($urandom);
                else if ($urandom_range(0, 1) == 0)     b = 10'($urandom_range(0, lim - 1));
                else b = 10'($urandom_range(0, (lim > 32) ? 31 : lim - 1));
                send_req(REQ_RELEASE, 16'($urandom), b);
            end else if (pick < 90) begin
                send_req(REQ_CLEAR, 16'($urandom), 10'($urandom));
            end else if (pick < 95) begin
                send_req(REQ_NONE, 16'($urandom), 10'($urandom));
            end else begin
                w = (cur_bytes == 65535) ? 16'hFFFF : 16'(cur_bytes + 1);
                send_req(REQ_ACQUIRE, w, 10'($urandom));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults: size limits, reuse order, double release,
        // the unused request type and a pool reset.
        send_req(REQ_ACQUIRE, 16'd0, 10'd0);
        send_req(REQ_ACQUIRE, 16'd8, 10'h3FF);
        send_req(REQ_ACQUIRE, 16'd9, 10'd0);
        send_req(REQ_ACQUIRE, 16'hFFFF, 10'd0);
        send_req(REQ_RELEASE, 16'hFFFF, 10'd1);
        send_req(REQ_RELEASE, 16'd0, 10'd0);
        send_req(REQ_ACQUIRE, 16'd8, 10'd0);
        send_req(REQ_ACQUIRE, 16'd3, 10'd0);
        send_req(REQ_ACQUIRE, 16'd0, 10'd0);
        send_req(REQ_RELEASE, 16'd0, 10'd2);
        send_req(REQ_RELEASE, 16'd0, 10'd2);
        send_req(REQ_ACQUIRE, 16'd1, 10'd0);
        send_req(REQ_ACQUIRE, 16'd1, 10'd0);
        send_req(REQ_NONE, 16'hFFFF, 10'h3FF);
        send_req(REQ_CLEAR, 16'd0, 10'd0);
        send_req(REQ_RELEASE, 16'd0, 10'd5);
        send_req(REQ_ACQUIRE, 16'd0, 10'd0);
        wait_idle();

        // Single block at the top of the address space with the widest blocks.
        program_regs(32'hFFFF_FFF0, 32'd65535, 32'd1, 1'b0);
        send_req(REQ_CLEAR, 16'd0, 10'd0);
        send_req(REQ_ACQUIRE, 16'hFFFF, 10'd0);
        send_req(REQ_ACQUIRE, 16'd0, 10'd0);
        send_req(REQ_RELEASE, 16'd0, 10'd1);
        send_req(REQ_RELEASE, 16'd0, 10'd0);
        run_random(150);
        wait_idle();

        // One-byte blocks and a count beyond the pool size; upper data bits are junk.
        program_regs($urandom, 32'hA5A5_0001, 32'hFFFF_F7FF, 1'b0);
        run_random(200);
        send_req(REQ_RELEASE, 16'd0, 10'd1000);
        send_req(REQ_RELEASE, 16'd0, 10'd700);
        wait_idle();

        // Empty pool: blocks still linked from before are handed out anyway.
        program_regs($urandom, 32'd16, 32'd0, 1'b0);
        send_req(REQ_ACQUIRE, 16'd16, 10'd0);
        send_req(REQ_ACQUIRE, 16'd0, 10'd0);
        send_req(REQ_RELEASE, 16'd0, 10'd0);
        run_random(80);
        wait_idle();

        // Small pool that runs dry often.
        program_regs($urandom, $urandom_range(1, 65535), 32'd16, 1'b1);
        run_random(400);
        wait_idle();

        program_regs(32'hFFFF_FFFF, $urandom_range(1, 65535), $urandom_range(1, 1024), 1'b0);
        run_random(250);
        wait_idle();

        // A block released twice links to itself, so acquires never run out
        // and the used count climbs steadily under back-to-back requests.
        program_regs(32'd0, 32'd8, 32'd1024, 1'b0);
        steady = 1'b1;
        send_req(REQ_CLEAR, 16'd0, 10'd0);
        send_req(REQ_RELEASE, 16'd0, 10'd3);
        send_req(REQ_RELEASE, 16'd0, 10'd3);
        repeat (600) send_req(REQ_ACQUIRE, 16'($urandom_range(0, 8)), 10'($urandom));
        steady = 1'b0;
        run_random(150);

        wait_idle();
        repeat (4) @(posedge i_clk);

        $display("Sent %0d requests under %0d register settings, %0d replies compared.",
                 items_sent, settings, checked);
        $display("Covered pool exhaustion, size limits, bad and double releases, shrunk %s",
                 "pools and long runs of back-to-back grants.");
        if (fail_count == 0 && pending == 0) begin
            $display("** fixed_block_pool_allocator: PASSED **");
        end else begin
            $display("%0d failures, %0d replies outstanding.", fail_count, pending);
            $display("** fixed_block_pool_allocator: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/fbpa_pkg.sv
rtl/fbpa_link_ram.sv
rtl/fbpa_ctrl.sv
rtl/fixed_block_pool_allocator.sv
tb/fbpa_checker.sv
tb/tb_top.sv
